### rtl/mpbec_pkg.sv
// shared types and constants for the memory pattern bit error checker
package mpbec_pkg;

  localparam int ERROR_SLOTS  = 1024;
  localparam int MEMORY_BYTES = 131072;
  localparam int SLOT_W       = 10;
  localparam int ADDR_W       = 17;
  localparam int CODE_W       = 23;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  BYTE_ZERO  = 8'h00;
  localparam logic [7:0]  BYTE_ONES  = 8'hFF;
  localparam logic [15:0] RUN_MAX    = 16'hFFFF;
  localparam logic [7:0]  STEP_RESET = 8'd1;
  localparam logic [15:0] LIMIT_RESET = 16'd100;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_START = 2'd0,
    CFG_PATTERN_STEP  = 2'd1,
    CFG_CHIP_ID       = 2'd2,
    CFG_BLANK_LIMIT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_CHECK  = 2'd1,
    JOB_ABORT  = 2'd2,
    JOB_SAVE   = 2'd3
  } job_kind_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] read_byte;
  } in_t;

  typedef struct packed {
    logic              record_valid;
    logic [CODE_W-1:0] error_code;
    logic [SLOT_W-1:0] slot_index;
    logic [SLOT_W-1:0] next_slot;
    logic              unresponsive;
    logic              pass_aborted;
    logic              last_result;
  } out_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [7:0]        diff;
    logic [CODE_W-4:0] base;
    logic              unresp;
    logic              aborted;
  } job_t;

endpackage

### rtl/mpbec_front.sv
// front end: configuration, pattern tracking, blank run and pass control
module mpbec_front import mpbec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  q_full,
  output logic                  push,
  output job_t                  job
);

  logic [7:0]        start_r;
  logic [7:0]        step_r;
  logic [2:0]        chip_r;
  logic [15:0]       limit_r;
  logic [7:0]        expected_r, expected_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [15:0]       run_r, run_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic              aborted_r, aborted_nxt;
  logic              unresp_r, unresp_nxt;
  logic [ADDR_W:0]   addr_inc;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign addr_inc = {1'b0, addr_r} + 1'b1;

  always_comb begin
    expected_nxt = expected_r;
    addr_nxt     = addr_r;
    run_nxt      = run_r;
    prev_nxt     = prev_r;
    aborted_nxt  = aborted_r;
    unresp_nxt   = unresp_r;
    job.kind     = JOB_STATUS;
    job.diff     = '0;
    job.base     = {chip_r, addr_r};
    case (in_data.command)
      CMD_START: begin
        expected_nxt = start_r;
        addr_nxt     = '0;
        run_nxt      = '0;
        prev_nxt     = BYTE_ZERO;
        aborted_nxt  = 1'b0;
      end
      CMD_CHECK: begin
        if (!aborted_r) begin
          if (run_r >= limit_r) begin
            aborted_nxt = 1'b1;
            unresp_nxt  = 1'b1;
            job.kind    = JOB_ABORT;
          end else begin
            if (prev_r == BYTE_ZERO || prev_r == BYTE_ONES) begin
              if (run_r != RUN_MAX) run_nxt = run_r + 16'd1;
            end else begin
              run_nxt = '0;
            end
            prev_nxt     = in_data.read_byte;
            job.kind     = JOB_CHECK;
            job.diff     = in_data.read_byte ^ expected_r;
            expected_nxt = expected_r + step_r;
            if (addr_inc >= (ADDR_W+1)'(MEMORY_BYTES)) begin
              addr_nxt = '0;
            end else begin
              addr_nxt = addr_inc[ADDR_W-1:0];
            end
          end
        end
      end
      CMD_END: begin
        if (!aborted_r && run_r < limit_r) begin
          unresp_nxt = 1'b0;
          job.kind   = JOB_SAVE;
        end
      end
      default: begin
      end
    endcase
    job.unresp  = unresp_nxt;
    job.aborted = aborted_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      step_r  <= STEP_RESET;
      chip_r  <= '0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_START: start_r <= cfg_wdata[7:0];
        CFG_PATTERN_STEP:  step_r  <= cfg_wdata[7:0];
        CFG_CHIP_ID:       chip_r  <= cfg_wdata[2:0];
        CFG_BLANK_LIMIT:   limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      addr_r     <= '0;
      run_r      <= '0;
      prev_r     <= '0;
      aborted_r  <= 1'b0;
      unresp_r   <= 1'b0;
    end else if (push) begin
      expected_r <= expected_nxt;
      addr_r     <= addr_nxt;
      run_r      <= run_nxt;
      prev_r     <= prev_nxt;
      aborted_r  <= aborted_nxt;
      unresp_r   <= unresp_nxt;
    end
  end

endmodule

### rtl/mpbec_queue.sv
// small job queue between front and back
module mpbec_queue import mpbec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/mpbec_back.sv
// back end: slot pointer, per-bit record emission and output register
module mpbec_back import mpbec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  job_t head_job,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [SLOT_W-1:0] saved_r, saved_nxt;
  logic              busy_r, busy_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic              out_valid_r;
  out_t              out_r, out_nxt;
  logic              fire;
  logic [7:0]        mask;
  logic [7:0]        rest;
  logic [2:0]        bit_num;
  logic [SLOT_W:0]   ptr_inc;

  assign fire      = head_valid && (!out_valid_r || out_ready);
  assign mask      = busy_r ? rem_r : head_job.diff;
  assign rest      = mask & (mask - 8'd1);
  assign ptr_inc   = {1'b0, ptr_r} + 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    bit_num = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i]) bit_num = 3'(i);
    end
  end

  always_comb begin
    ptr_nxt   = ptr_r;
    saved_nxt = saved_r;
    busy_nxt  = 1'b0;
    rem_nxt   = rem_r;
    pop       = fire;
    out_nxt.record_valid = 1'b0;
    out_nxt.error_code   = '0;
    out_nxt.slot_index   = '0;
    out_nxt.unresponsive = head_job.unresp;
    out_nxt.pass_aborted = head_job.aborted;
    out_nxt.last_result  = 1'b1;
    case (head_job.kind)
      JOB_ABORT: ptr_nxt   = saved_r;
      JOB_SAVE:  saved_nxt = ptr_r;
      JOB_CHECK: begin
        if (mask != '0) begin
          out_nxt.record_valid = 1'b1;
          out_nxt.error_code   = {head_job.base, bit_num};
          out_nxt.slot_index   = ptr_r;
          out_nxt.last_result  = (rest == '0);
          ptr_nxt = (ptr_inc >= (SLOT_W+1)'(ERROR_SLOTS)) ? '0 : ptr_inc[SLOT_W-1:0];
          if (rest != '0) begin
            busy_nxt = 1'b1;
            rem_nxt  = rest;
            pop      = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.next_slot = ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      saved_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        ptr_r   <= ptr_nxt;
        saved_r <= saved_nxt;
        busy_r  <= busy_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rem_r <= rem_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

### rtl/memory_pattern_bit_error_checker_core.sv
// top level of the memory pattern bit error checker
//
//   channel  signals                          carries
//   in       in_valid / in_ready / in_data    one command request
//   out      out_valid / out_ready / out_data one error record or status
//   cfg      cfg_we / cfg_index / cfg_wdata   register write, no wait
//
// a request is taken every cycle while the four-entry job queue has room
// the back end emits one result per cycle unless the output stalls; a byte
// with n differing bits gives n results (at least one) from the single emitter
// reset is synchronous, active low, and clears all control registers
// a stalled output holds its register; the queue takes requests till full
module memory_pattern_bit_error_checker_core import mpbec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  mpbec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  mpbec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mpbec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### dv/tb_memory_pattern_bit_error_checker_core.sv
// testbench for the memory pattern bit error checker core, checked against a predictor
module tb_memory_pattern_bit_error_checker_core;
  import mpbec_pkg::*;

  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int         CYCLE_LIMIT  = 100000;
  localparam int         DRAIN_WAIT   = 4;

  typedef struct {
    logic      is_cfg;
    cfg_idx_t  idx;
    logic [15:0] value;
    in_t       req;
    logic      typed;
    out_t      want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;

  memory_pattern_bit_error_checker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // predictor configuration and state
  logic [7:0]        pat_start = 8'd0;
  logic [7:0]        pat_step  = STEP_RESET;
  logic [2:0]        chip      = 3'd0;
  logic [15:0]       blank_lim = LIMIT_RESET;
  logic [7:0]        exp_byte  = '0;
  logic [ADDR_W-1:0] byte_addr = '0;
  logic [15:0]       blank_run = '0;
  logic [7:0]        prev_byte = '0;
  logic [SLOT_W-1:0] wr_ptr    = '0;
  logic [SLOT_W-1:0] saved_ptr = '0;
  logic              aborted   = 1'b0;
  logic              unresp    = 1'b0;

  out_t predicted_records[$];
  out_t expected_records[$];
  int   mismatch_count = 0;
  int   idle_mode = 0;
  int   hold_left = 0;
  int unsigned cycle_count = 0;

  function automatic out_t make_result(logic valid, logic [CODE_W-1:0] code,
                                       logic [SLOT_W-1:0] slot, logic last);
    out_t r;
    r.record_valid = valid;
    r.error_code   = code;
    r.slot_index   = slot;
    r.next_slot    = wr_ptr;
    r.unresponsive = unresp;
    r.pass_aborted = aborted;
    r.last_result  = last;
    return r;
  endfunction

  task automatic apply_command(input in_t req);
    logic [7:0]        diff;
    logic [SLOT_W-1:0] slot;
    predicted_records.delete();
    case (req.command)
      CMD_START: begin
        exp_byte  = pat_start;
        byte_addr = '0;
        blank_run = '0;
        prev_byte = '0;
        aborted   = 1'b0;
      end
      CMD_CHECK: begin
        if (!aborted) begin
          if (blank_run >= blank_lim) begin
            wr_ptr  = saved_ptr;
            unresp  = 1'b1;
            aborted = 1'b1;
          end else begin
            if (prev_byte == BYTE_ZERO || prev_byte == BYTE_ONES) begin
              if (blank_run != RUN_MAX) blank_run = blank_run + 1'b1;
            end else begin
              blank_run = '0;
            end
            prev_byte = req.read_byte;
            diff = req.read_byte ^ exp_byte;
            for (int b = 0; b < 8; b++) begin
              if (diff[b]) begin
                slot = wr_ptr;
                wr_ptr = (int'(wr_ptr) == ERROR_SLOTS - 1) ? '0 : wr_ptr + 1'b1;
                predicted_records.push_back(make_result(1'b1, {chip, byte_addr, 3'(b)},
                                                        slot, 1'b0));
              end
            end
            exp_byte  = exp_byte + pat_step;
            byte_addr = (int'(byte_addr) == MEMORY_BYTES - 1) ? '0 : byte_addr + 1'b1;
          end
        end
      end
      CMD_END: begin
        if (!aborted && blank_run < blank_lim) begin
          saved_ptr = wr_ptr;
          unresp    = 1'b0;
        end
      end
      default: ;
    endcase
    if (predicted_records.size() == 0)
      predicted_records.push_back(make_result(1'b0, '0, '0, 1'b1));
    else
      predicted_records[predicted_records.size() - 1].last_result = 1'b1;
  endtask

  function automatic in_t mk_req(logic [1:0] cmd, logic [7:0] b);
    in_t r;
    r.command   = cmd;
    r.read_byte = b;
    return r;
  endfunction

  function automatic out_t status_result(logic [SLOT_W-1:0] next, logic unr, logic ab);
    out_t r;
    r = '0;
    r.next_slot    = next;
    r.unresponsive = unr;
    r.pass_aborted = ab;
    r.last_result  = 1'b1;
    return r;
  endfunction

  function automatic row_t request_row(logic [1:0] cmd, logic [7:0] b);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CFG_PATTERN_START;
    r.value  = '0;
    r.req    = mk_req(cmd, b);
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic row_t typed_row(logic [1:0] cmd, logic [7:0] b, out_t want);
    row_t r;
    r = request_row(cmd, b);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t config_row(cfg_idx_t idx, logic [15:0] v);
    row_t r;
    r = request_row(CMD_START, 8'h00);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = v;
    return r;
  endfunction

  task automatic send_request(input in_t req, input logic typed = 1'b0,
                              input out_t want = '0);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 33 : 0;
    while ($urandom_range(99, 0) < pct) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    apply_command(req);
    if (typed) expected_records.push_back(want);
    else expected_records = {expected_records, predicted_records};
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_PATTERN_START: pat_start = value[7:0];
      CFG_PATTERN_STEP:  pat_step  = value[7:0];
      CFG_CHIP_ID:       chip      = value[2:0];
      CFG_BLANK_LIMIT:   blank_lim = value;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] flip_mask();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 5) return 8'h00;
    if (pick < 8) return 8'(1 << $urandom_range(7, 0));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(5, 0))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'd0;
      3, 4: return 16'($urandom_range(6, 1));
      default: return 16'($urandom_range(40, 2));
    endcase
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      case (idle_mode)
        2: out_ready = ($urandom_range(99, 0) >= 62);
        3: out_ready = ($urandom_range(99, 0) >= 33);
        default: out_ready = 1'b1;
      endcase
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        want = expected_records.pop_front();
        report_field("record_valid", 32'(want.record_valid), 32'(out_data.record_valid));
        report_field("error_code", 32'(want.error_code), 32'(out_data.error_code));
        report_field("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
        report_field("next_slot", 32'(want.next_slot), 32'(out_data.next_slot));
        report_field("unresponsive", 32'(want.unresponsive),
                     32'(out_data.unresponsive));
        report_field("pass_aborted", 32'(want.pass_aborted), 32'(out_data.pass_aborted));
        report_field("last_result", 32'(want.last_result), 32'(out_data.last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_memory_pattern_bit_error_checker_core: errors");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int   sent;
    int   n;
    logic paused;
    logic burst;

    // reset values first, then extremes of start, step, chip and limit
    rows.push_back(typed_row(CMD_END, 8'h00, status_result(10'd0, 1'b0, 1'b0)));
    rows.push_back(typed_row(CMD_RESERVED, 8'hFF, status_result(10'd0, 1'b0, 1'b0)));
    rows.push_back(typed_row(CMD_CHECK, 8'h00, status_result(10'd0, 1'b0, 1'b0)));
    rows.push_back(typed_row(CMD_START, 8'hA5, status_result(10'd0, 1'b0, 1'b0)));
    rows.push_back(typed_row(CMD_CHECK, 8'h00, status_result(10'd0, 1'b0, 1'b0)));
    rows.push_back(typed_row(CMD_CHECK, 8'h01, status_result(10'd0, 1'b0, 1'b0)));
    rows.push_back(request_row(CMD_CHECK, 8'hFD));
    rows.push_back(request_row(CMD_CHECK, 8'hFF));
    rows.push_back(typed_row(CMD_END, 8'h00, status_result(10'd14, 1'b0, 1'b0)));
    rows.push_back(config_row(CFG_CHIP_ID, 16'd7));
    rows.push_back(config_row(CFG_PATTERN_START, 16'h00FF));
    rows.push_back(config_row(CFG_PATTERN_STEP, 16'h00FF));
    rows.push_back(typed_row(CMD_START, 8'h00, status_result(10'd14, 1'b0, 1'b0)));
    rows.push_back(typed_row(CMD_CHECK, 8'h7F,
                             out_t'{1'b1, 23'h700007, 10'd14, 10'd15, 1'b0, 1'b0, 1'b1}));
    rows.push_back(request_row(CMD_CHECK, 8'hFE));
    rows.push_back(config_row(CFG_BLANK_LIMIT, 16'd1));
    rows.push_back(request_row(CMD_START, 8'h00));
    rows.push_back(request_row(CMD_CHECK, 8'h00));
    rows.push_back(typed_row(CMD_CHECK, 8'h12, status_result(10'd14, 1'b1, 1'b1)));
    rows.push_back(typed_row(CMD_CHECK, 8'h00, status_result(10'd14, 1'b1, 1'b1)));
    rows.push_back(typed_row(CMD_END, 8'h00, status_result(10'd14, 1'b1, 1'b1)));
    rows.push_back(typed_row(CMD_START, 8'h00, status_result(10'd14, 1'b1, 1'b0)));
    rows.push_back(config_row(CFG_BLANK_LIMIT, 16'd0));
    rows.push_back(typed_row(CMD_CHECK, 8'h55, status_result(10'd14, 1'b1, 1'b1)));
    rows.push_back(config_row(CFG_BLANK_LIMIT, 16'hFFFF));
    rows.push_back(config_row(CFG_PATTERN_STEP, 16'd0));
    rows.push_back(typed_row(CMD_START, 8'h00, status_result(10'd14, 1'b1, 1'b0)));
    rows.push_back(typed_row(CMD_END, 8'h00, status_result(10'd14, 1'b0, 1'b0)));
    rows.push_back(request_row(CMD_CHECK, 8'hFF));
    rows.push_back(request_row(CMD_CHECK, 8'h00));
    rows.push_back(request_row(CMD_END, 8'h00));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drain();
        write_register(rows[i].idx, rows[i].value);
      end else begin
        send_request(rows[i].req, rows[i].typed, rows[i].want);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      wait_drain();
      idle_mode = phase % 4;
      write_register(CFG_PATTERN_START, 16'($urandom_range(255, 0)));
      write_register(CFG_PATTERN_STEP, 16'($urandom_range(255, 0)));
      write_register(CFG_CHIP_ID, 16'($urandom_range(7, 0)));
      write_register(CFG_BLANK_LIMIT, pick_limit());
      // long receiver hold-off while requests keep coming
      if (phase == 2) hold_left = 300;
      sent = 0;
      paused = 1'b0;
      while (sent < 20) begin
        if (phase == 5 && sent >= 10 && !paused) begin
          wait_drain();
          paused = 1'b1;
        end
        if ($urandom_range(9, 0) < 7) begin
          send_request(mk_req(CMD_START, 8'($urandom_range(255, 0))));
          sent++;
          n = $urandom_range(8, 1);
          for (int j = 0; j < n; j++) begin
            send_request(mk_req(CMD_CHECK, exp_byte ^ flip_mask()));
            sent++;
          end
          burst = (blank_lim <= 16) && ($urandom_range(3, 0) == 0);
          if (burst) begin
            repeat (int'(blank_lim) + 2) begin
              send_request(mk_req(CMD_CHECK, $urandom_range(1, 0) ? BYTE_ONES : BYTE_ZERO));
              sent++;
            end
          end
          if ($urandom_range(9, 0) != 0) begin
            send_request(mk_req(CMD_END, 8'($urandom_range(255, 0))));
            sent++;
          end
        end else begin
          send_request(mk_req(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0))));
          sent++;
        end
      end
    end

    wait_drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_records.size() == 0) begin
      $display("tb_memory_pattern_bit_error_checker_core: clean");
    end else begin
      $display("tb_memory_pattern_bit_error_checker_core: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/mpbec_pkg.sv
rtl/mpbec_front.sv
rtl/mpbec_queue.sv
rtl/mpbec_back.sv
rtl/memory_pattern_bit_error_checker_core.sv
dv/tb_memory_pattern_bit_error_checker_core.sv
